// ----- rtl/core/esc_pkg.sv -----
// Shared types and constants for the epoch-seconds to calendar converter.
// Holds the controller state enum, command/status structs, divider constants
// and the month table. No dependencies.
`default_nettype none

package esc_pkg;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DAY_GO,
    ST_DAY_WAIT,
    ST_HOUR_GO,
    ST_HOUR_WAIT,
    ST_MIN_GO,
    ST_MIN_WAIT,
    ST_YEAR_GO,
    ST_YEAR_WAIT,
    ST_BASE,
    ST_FIX,
    ST_MONTH,
    ST_DONE
  } state_e;

  // Which division the shared divider performs
  typedef enum logic [1:0] {
    DIV_DAY,
    DIV_HOUR,
    DIV_MIN,
    DIV_YEAR
  } div_sel_e;

  // Controller -> datapath
  typedef struct packed {
    logic     load;
    logic     div_start;
    logic     div_take;
    div_sel_e div_sel;
    logic     base_calc;
    logic     year_fix;
    logic     month_step;
    logic     publish;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic div_done;
    logic year_high;
    logic month_end;
  } status_t;

  localparam int unsigned DivW  = 32;
  localparam int unsigned DvsW  = 17;
  localparam int unsigned MulAW = 25;
  localparam int unsigned MulBW = 26;

  localparam logic [DvsW-1:0] SecsPerDay  = 17'd86400;
  localparam logic [DvsW-1:0] SecsPerHour = 17'd3600;
  localparam logic [DvsW-1:0] SecsPerMin  = 17'd60;
  localparam logic [DvsW-1:0] DaysPerYear = 17'd365;

  // Reciprocals, rounded up; exact over the operand ranges used
  localparam logic [MulBW-1:0] RecipDay  = 26'd50903317;  // 2^35 / 675, on secs >> 7
  localparam logic [MulBW-1:0] RecipHour = 26'd149131;    // 2^29 / 3600
  localparam logic [MulBW-1:0] RecipMin  = 26'd139811;    // 2^23 / 60
  localparam logic [MulBW-1:0] RecipYear = 26'd91930;     // 2^25 / 365

  localparam logic [11:0] EpochYear   = 12'd1970;
  localparam logic [11:0] SkipLeapYr  = 12'd2100;  // century year that is not leap
  localparam logic [17:0] DaysYearW   = 18'd365;
  localparam logic [17:0] LeapBase    = 18'd492;   // 1969 / 4
  localparam logic [3:0]  MonthLast   = 4'd11;     // December, zero based

  // Days in month (zero based), February follows the leap flag
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    unique case (mon)
      4'd1:                      len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/esc_divider.sv -----
// Constant divider shared by the four divisions of the converter: reciprocal
// multiply for the quotient, then multiply and subtract for the remainder.
// Depends on esc_pkg.
`default_nettype none

module esc_divider (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire esc_pkg::div_sel_e         sel_i,
  input  wire logic [esc_pkg::DivW-1:0]  dividend_i,
  output logic      [esc_pkg::DivW-1:0]  quot_o,
  output logic      [esc_pkg::DvsW-1:0]  rem_o,
  output logic                           done_o
);

  localparam int unsigned ProdW = esc_pkg::MulAW + esc_pkg::MulBW;

  logic                        mul_q;   // operand loaded, quotient this cycle
  logic                        sub_q;   // quotient held, remainder this cycle
  logic                        done_q;
  esc_pkg::div_sel_e           sel_q;
  logic [esc_pkg::MulAW-1:0]   opnd_q;
  logic [esc_pkg::DvsW-1:0]    low_q;
  logic [15:0]                 quot_q;
  logic [esc_pkg::DvsW-1:0]    rem_q;
  logic [esc_pkg::MulAW-1:0]   opnd_d;
  logic [esc_pkg::MulBW-1:0]   recip;
  logic [esc_pkg::DvsW-1:0]    dvs;
  logic [ProdW-1:0]            prod;
  logic [15:0]                 quot_d;

  // multiplier operand; days use secs >> 7 since 86400 = 128 * 675
  always_comb begin
    if (sel_i == esc_pkg::DIV_DAY) begin
      opnd_d = dividend_i[esc_pkg::DivW-1:7];
    end else begin
      opnd_d = {8'd0, dividend_i[esc_pkg::DvsW-1:0]};
    end
  end

  // constants for the division in flight
  always_comb begin
    unique case (sel_q)
      esc_pkg::DIV_DAY: begin
        recip = esc_pkg::RecipDay;
        dvs   = esc_pkg::SecsPerDay;
      end
      esc_pkg::DIV_HOUR: begin
        recip = esc_pkg::RecipHour;
        dvs   = esc_pkg::SecsPerHour;
      end
      esc_pkg::DIV_MIN: begin
        recip = esc_pkg::RecipMin;
        dvs   = esc_pkg::SecsPerMin;
      end
      esc_pkg::DIV_YEAR: begin
        recip = esc_pkg::RecipYear;
        dvs   = esc_pkg::DaysPerYear;
      end
      default: begin
        recip = esc_pkg::RecipDay;
        dvs   = esc_pkg::SecsPerDay;
      end
    endcase
  end

  // quotient = (operand * reciprocal) >> shift
  always_comb begin
    prod = {{esc_pkg::MulBW{1'b0}}, opnd_q} * {{esc_pkg::MulAW{1'b0}}, recip};
    unique case (sel_q)
      esc_pkg::DIV_DAY:  quot_d = prod[50:35];
      esc_pkg::DIV_HOUR: quot_d = prod[44:29];
      esc_pkg::DIV_MIN:  quot_d = prod[38:23];
      esc_pkg::DIV_YEAR: quot_d = prod[40:25];
      default:           quot_d = prod[50:35];
    endcase
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q  <= 1'b0;
      sub_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      mul_q  <= start_i;
      sub_q  <= mul_q;
      done_q <= sub_q;
    end
  end

  // operands and results; remainder fits in the low DvsW bits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sel_q  <= sel_i;
      opnd_q <= opnd_d;
      low_q  <= dividend_i[esc_pkg::DvsW-1:0];
    end
    if (mul_q) begin
      quot_q <= quot_d;
    end
    if (sub_q) begin
      rem_q <= low_q - ({1'b0, quot_q} * dvs);
    end
  end

  assign quot_o = {{(esc_pkg::DivW-16){1'b0}}, quot_q};
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// ----- rtl/core/esc_datapath.sv -----
// Datapath: working registers, shared divider, year fixup and month walk.
// Driven by esc_ctrl through cmd_t. Depends on esc_pkg and esc_divider.
`default_nettype none

module esc_datapath (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [31:0]      epoch_seconds_i,
  input  wire esc_pkg::cmd_t    cmd_i,
  output esc_pkg::status_t      status_o,
  output logic                  result_valid_o,
  output logic [11:0]           year_o,
  output logic [3:0]            month_o,
  output logic [4:0]            day_of_month_o,
  output logic [4:0]            hour_o,
  output logic [5:0]            minute_o,
  output logic [5:0]            second_o
);

  logic [31:0]                 t_q;
  logic [15:0]                 days_q;
  logic [16:0]                 rem_q;
  logic [11:0]                 year_q;
  logic [15:0]                 base_q;
  logic [3:0]                  mon_q;
  logic [4:0]                  hour_q;
  logic [5:0]                  minute_q;
  logic [5:0]                  second_q;
  logic                        valid_q;

  logic [esc_pkg::DivW-1:0]    dividend;
  logic [esc_pkg::DivW-1:0]    quot;
  logic [esc_pkg::DvsW-1:0]    div_rem;
  logic                        div_done;

  logic [11:0]                 year_off;
  logic [11:0]                 year_m1;
  logic                        past_skip;
  logic [17:0]                 base_next;
  logic                        leap;
  logic [4:0]                  mlen;

  // divider operand select
  always_comb begin
    unique case (cmd_i.div_sel)
      esc_pkg::DIV_DAY: begin
        dividend = t_q;
      end
      esc_pkg::DIV_HOUR: begin
        dividend = {15'd0, rem_q};
      end
      esc_pkg::DIV_MIN: begin
        dividend = {15'd0, rem_q};
      end
      esc_pkg::DIV_YEAR: begin
        dividend = {16'd0, days_q};
      end
      default: begin
        dividend = t_q;
      end
    endcase
  end

  esc_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .sel_i      (cmd_i.div_sel),
    .dividend_i (dividend),
    .quot_o     (quot),
    .rem_o      (div_rem),
    .done_o     (div_done)
  );

  // Days before Jan 1 of year_q. Years are bounded to 1970..2106 by the
  // 32-bit input, so the only century terms are 2000 (leap) and 2100 (not).
  always_comb begin
    year_off  = year_q - esc_pkg::EpochYear;
    year_m1   = year_q - 12'd1;
    past_skip = (year_q > esc_pkg::SkipLeapYr);
    base_next = {10'd0, year_off[7:0]} * esc_pkg::DaysYearW
              + {8'd0, year_m1[11:2]} - esc_pkg::LeapBase - {17'd0, past_skip};
    leap      = (year_q[1:0] == 2'b00) && (year_q != esc_pkg::SkipLeapYr);
    mlen      = esc_pkg::month_len(mon_q, leap);
  end

  always_comb begin
    status_o.div_done  = div_done;
    status_o.year_high = (days_q < base_q);
    status_o.month_end = (mon_q == esc_pkg::MonthLast) || (days_q < {11'd0, mlen});
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      t_q <= epoch_seconds_i;
    end
    if (cmd_i.div_take) begin
      unique case (cmd_i.div_sel)
        esc_pkg::DIV_DAY: begin
          days_q <= quot[15:0];
          rem_q  <= div_rem;
        end
        esc_pkg::DIV_HOUR: begin
          hour_q <= quot[4:0];
          rem_q  <= div_rem;
        end
        esc_pkg::DIV_MIN: begin
          minute_q <= quot[5:0];
          second_q <= div_rem[5:0];
        end
        esc_pkg::DIV_YEAR: begin
          year_q <= esc_pkg::EpochYear + {4'd0, quot[7:0]};
        end
        default: begin
          days_q <= quot[15:0];
        end
      endcase
    end
    if (cmd_i.base_calc) begin
      base_q <= base_next[15:0];
    end
    // estimate too high by one year at most
    if (cmd_i.year_fix) begin
      mon_q <= '0;
      if (status_o.year_high) begin
        year_q <= year_q - 12'd1;
      end else begin
        days_q <= days_q - base_q;
      end
    end
    // one month per cycle
    if (cmd_i.month_step && !status_o.month_end) begin
      days_q <= days_q - {11'd0, mlen};
      mon_q  <= mon_q + 4'd1;
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      year_o         <= year_q;
      month_o        <= mon_q + 4'd1;
      day_of_month_o <= days_q[4:0] + 5'd1;
      hour_o         <= hour_q;
      minute_o       <= minute_q;
      second_o       <= second_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.publish;
    end
  end

  assign result_valid_o = valid_q;

endmodule

`default_nettype wire

// ----- rtl/core/esc_ctrl.sv -----
// Controller FSM: sequences the four divisions, year fixup and month walk.
// Talks to esc_datapath via cmd_t / status_t. Depends on esc_pkg.
`default_nettype none

module esc_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  input  wire esc_pkg::status_t   status_i,
  output esc_pkg::cmd_t           cmd_o,
  output logic                    busy
);

  esc_pkg::state_e state_q;
  esc_pkg::state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= esc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.div_sel = esc_pkg::DIV_DAY;
    unique case (state_q)
      esc_pkg::ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = esc_pkg::ST_DAY_GO;
        end
      end
      esc_pkg::ST_DAY_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = esc_pkg::ST_DAY_WAIT;
      end
      esc_pkg::ST_DAY_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d        = esc_pkg::ST_HOUR_GO;
        end
      end
      esc_pkg::ST_HOUR_GO: begin
        cmd_o.div_sel   = esc_pkg::DIV_HOUR;
        cmd_o.div_start = 1'b1;
        state_d         = esc_pkg::ST_HOUR_WAIT;
      end
      esc_pkg::ST_HOUR_WAIT: begin
        cmd_o.div_sel = esc_pkg::DIV_HOUR;
        if (status_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d        = esc_pkg::ST_MIN_GO;
        end
      end
      esc_pkg::ST_MIN_GO: begin
        cmd_o.div_sel   = esc_pkg::DIV_MIN;
        cmd_o.div_start = 1'b1;
        state_d         = esc_pkg::ST_MIN_WAIT;
      end
      esc_pkg::ST_MIN_WAIT: begin
        cmd_o.div_sel = esc_pkg::DIV_MIN;
        if (status_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d        = esc_pkg::ST_YEAR_GO;
        end
      end
      esc_pkg::ST_YEAR_GO: begin
        cmd_o.div_sel   = esc_pkg::DIV_YEAR;
        cmd_o.div_start = 1'b1;
        state_d         = esc_pkg::ST_YEAR_WAIT;
      end
      esc_pkg::ST_YEAR_WAIT: begin
        cmd_o.div_sel = esc_pkg::DIV_YEAR;
        if (status_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d        = esc_pkg::ST_BASE;
        end
      end
      esc_pkg::ST_BASE: begin
        cmd_o.base_calc = 1'b1;
        state_d         = esc_pkg::ST_FIX;
      end
      // a too-high estimate steps the year back and recomputes the base
      esc_pkg::ST_FIX: begin
        cmd_o.year_fix = 1'b1;
        state_d = status_i.year_high ? esc_pkg::ST_BASE : esc_pkg::ST_MONTH;
      end
      esc_pkg::ST_MONTH: begin
        cmd_o.month_step = 1'b1;
        if (status_i.month_end) begin
          state_d = esc_pkg::ST_DONE;
        end
      end
      esc_pkg::ST_DONE: begin
        cmd_o.publish = 1'b1;
        state_d       = esc_pkg::ST_IDLE;
      end
      default: begin
        state_d = esc_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != esc_pkg::ST_IDLE);

endmodule

`default_nettype wire

// ----- rtl/core/epoch_seconds_to_calendar.sv -----
// Top level of the epoch-seconds to calendar converter.
// Instantiates esc_ctrl and esc_datapath; uses esc_pkg types.
`default_nettype none

// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into
// Gregorian year, month, day of month, hour, minute and second.
//
// Command channel: a transaction is taken at a rising edge with start high
// and busy low; epoch_seconds_i is sampled at that edge. busy stays high
// while the item is worked on, and one item is converted at a time.
//
// Result channel: result_valid_o is high for exactly one cycle and the
// fields are valid in that cycle. The receiver cannot stall; the result
// registers hold until the next result overwrites them.
//
// Sequence: the four divisions (days, hours, minutes, years) run one after
// another in the shared constant divider; then the year base is computed, a
// year estimate that is one too high is stepped back with the base computed
// again, and the month walk steps through the months passed. busy drops in
// the cycle the strobe is shown, so a new item can follow it.
//
// Reset (rst_ni low, asynchronous): controller returns to idle, no strobe.

module epoch_seconds_to_calendar (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] epoch_seconds_i,
  output logic             result_valid_o,
  output logic [11:0]      year_o,
  output logic [3:0]       month_o,
  output logic [4:0]       day_of_month_o,
  output logic [4:0]       hour_o,
  output logic [5:0]       minute_o,
  output logic [5:0]       second_o
);

  esc_pkg::cmd_t    cmd;
  esc_pkg::status_t status;

  esc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  esc_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .epoch_seconds_i (epoch_seconds_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .result_valid_o  (result_valid_o),
    .year_o          (year_o),
    .month_o         (month_o),
    .day_of_month_o  (day_of_month_o),
    .hour_o          (hour_o),
    .minute_o        (minute_o),
    .second_o        (second_o)
  );

`ifndef SYNTHESIS
  // an accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transaction");

  // the strobe comes only once the item is finished
  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

  // one strobe per transaction
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  // calendar fields stay in range
  a_field_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (month_o >= 4'd1 && month_o <= 4'd12 &&
                        day_of_month_o != 5'd0 && hour_o <= 5'd23 &&
                        minute_o <= 6'd59 && second_o <= 6'd59 &&
                        year_o >= 12'd1970 && year_o <= 12'd2106))
    else $error("calendar field out of range");
`endif

endmodule

`default_nettype wire
